// ===== rtl/packed_glyph_cell_blit_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the packed glyph cell blit
// Clocked implication checks with reset disable.
// ----------------------------------------------------------------------------
`ifndef PACKED_GLYPH_CELL_BLIT_MACROS_SVH
`define PACKED_GLYPH_CELL_BLIT_MACROS_SVH

// Same-cycle implication.
`define PGCB_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pgcb assertion failed");

// Next-cycle implication.
`define PGCB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pgcb assertion failed");

`endif

// ===== rtl/pgcb_pkg.sv =====
// ----------------------------------------------------------------------------
// pgcb_pkg
// Shared constants and types of the packed glyph cell blit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pgcb_pkg;

    localparam int DEF_MAX_CELL_WIDTH  = 32;
    localparam int DEF_MAX_CELL_HEIGHT = 32;
    localparam int DEF_MAX_GLYPH_SIDE  = 64;

    // One lane per pixel of a source byte.
    localparam int LANES  = 8;
    localparam int SEL_W  = $clog2(LANES);

    localparam logic [7:0] LEFT_BIT   = 8'h80;
    localparam logic [2:0] MAX_STRIDE = 3'd4;

    localparam logic [5:0] RESET_CELL_WIDTH  = 6'd8;
    localparam logic [5:0] RESET_CELL_HEIGHT = 6'd16;
    localparam logic [2:0] RESET_ROW_STRIDE  = 3'd1;

    // Register indexes (paddr[3:2]).
    localparam logic [1:0] REG_CELL_WIDTH  = 2'd0;
    localparam logic [1:0] REG_CELL_HEIGHT = 2'd1;
    localparam logic [1:0] REG_ROW_STRIDE  = 2'd2;

    // Saturated cell limits used by the lanes.
    typedef struct packed {
        logic [6:0] cw;
        logic [6:0] ch;
        logic [2:0] st;
    } pgcb_lim_t;

    typedef struct packed {
        logic [6:0] byte_index;
        logic [7:0] bit_mask;
    } pgcb_write_t;

endpackage

`default_nettype wire

// ===== rtl/packed_glyph_cell_blit.sv =====
// Path: the writes of a byte pass the lane input registers, the merge buffer
// and the output register in that order.
// Throughput, while out_stall is low: one write beat per cycle; a byte holds the merge stage
// until all its writes (up to eight) are out, and bytes with at most one write enter every cycle.
// Reset (rst_n, asynchronous): counters zero, pipeline empty, cell 8 by 16, stride 1.
// ----------------------------------------------------------------------------
// packed_glyph_cell_blit
// Top level: stream counters, eight pixel lanes, merge stage and registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module packed_glyph_cell_blit #(
    parameter int MAX_CELL_WIDTH  = pgcb_pkg::DEF_MAX_CELL_WIDTH,
    parameter int MAX_CELL_HEIGHT = pgcb_pkg::DEF_MAX_CELL_HEIGHT,
    parameter int MAX_GLYPH_SIDE  = pgcb_pkg::DEF_MAX_GLYPH_SIDE
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic [7:0]          src_byte,
    input  wire logic                first_byte,
    input  wire logic [6:0]          glyph_width,
    input  wire logic [6:0]          glyph_height,
    input  wire logic signed [15:0]  x_offset,
    input  wire logic signed [15:0]  y_offset,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic [6:0]               byte_index,
    output logic [7:0]               bit_mask,
    output logic                     last_of_run,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [3:0]          paddr,
    input  wire logic [31:0]         pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);
    import pgcb_pkg::*;

    localparam int COL_W = $clog2(MAX_GLYPH_SIDE);
    localparam int ROW_W = $clog2(MAX_GLYPH_SIDE + 1);

    pgcb_lim_t           lim;
    logic [COL_W-1:0]    col_reg;
    logic [ROW_W-1:0]    row_reg;
    logic [COL_W-1:0]    col_next;
    logic [ROW_W-1:0]    row_next;
    logic [COL_W-1:0]    pos_col [LANES];
    logic [ROW_W-1:0]    pos_row [LANES];
    logic [LANES-1:0]    pos_on;
    logic                size_ok;
    logic                accept;

    logic                a_valid_reg;
    logic [COL_W-1:0]    a_col_reg [LANES];
    logic [ROW_W-1:0]    a_row_reg [LANES];
    logic [LANES-1:0]    a_on_reg;
    logic signed [15:0]  a_dx_reg;
    logic signed [15:0]  a_dy_reg;

    logic [LANES-1:0]    lane_hit;
    pgcb_write_t [LANES-1:0] lane_wr;
    logic                drain_ready;

    assign pready   = 1'b1;
    assign in_stall = a_valid_reg && !drain_ready;
    assign accept   = in_valid && !in_stall;

    assign size_ok = (glyph_width != '0) && (glyph_height != '0) &&
                     (glyph_width <= 7'(MAX_GLYPH_SIDE)) &&
                     (glyph_height <= 7'(MAX_GLYPH_SIDE));

    // Walk the stream position across the eight bits of the byte. Once the row
    // reaches the glyph height the position freezes and later bits are dropped.
    always_comb
    begin
        logic [COL_W-1:0] c;
        logic [ROW_W-1:0] r;
        logic             live;
        c = first_byte ? '0 : col_reg;
        r = first_byte ? '0 : row_reg;
        for (int k = 0; k < LANES; k++)
        begin
            live       = (8'(r) < 8'(glyph_height));
            pos_col[k] = c;
            pos_row[k] = r;
            pos_on[k]  = size_ok && live && src_byte[LANES - 1 - k];
            if (size_ok && live)
            begin
                if ((8'(c) + 8'd1) >= 8'(glyph_width))
                begin
                    c = '0;
                    r = ROW_W'(r + 1'b1);
                end
                else
                begin
                    c = COL_W'(c + 1'b1);
                end
            end
        end
        col_next = c;
        row_next = r;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg     <= '0;
            row_reg     <= '0;
            a_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                col_reg     <= col_next;
                row_reg     <= row_next;
                a_valid_reg <= 1'b1;
            end
            else if (drain_ready)
            begin
                a_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_col_reg <= pos_col;
            a_row_reg <= pos_row;
            a_on_reg  <= pos_on;
            a_dx_reg  <= x_offset;
            a_dy_reg  <= y_offset;
        end
    end

    pgcb_regs #(
        .MAX_CELL_WIDTH  (MAX_CELL_WIDTH),
        .MAX_CELL_HEIGHT (MAX_CELL_HEIGHT)
    ) u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .lim     (lim)
    );

    for (genvar g = 0; g < LANES; g++)
    begin : g_lane
        pgcb_lane #(
            .COL_W (COL_W),
            .ROW_W (ROW_W)
        ) u_lane (
            .pixel_on (a_on_reg[g]),
            .col      (a_col_reg[g]),
            .row      (a_row_reg[g]),
            .x_offset (a_dx_reg),
            .y_offset (a_dy_reg),
            .lim      (lim),
            .hit      (lane_hit[g]),
            .wr       (lane_wr[g])
        );
    end

    pgcb_drain u_drain (
        .clk         (clk),
        .rst_n       (rst_n),
        .load_valid  (a_valid_reg),
        .load_hits   (lane_hit),
        .load_writes (lane_wr),
        .load_ready  (drain_ready),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .byte_index  (byte_index),
        .bit_mask    (bit_mask),
        .last_of_run (last_of_run)
    );

endmodule

`default_nettype wire

// ===== rtl/pgcb_regs.sv =====
// ----------------------------------------------------------------------------
// pgcb_regs
// APB register file holding the cell geometry, with saturated limits out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pgcb_regs #(
    parameter int MAX_CELL_WIDTH  = pgcb_pkg::DEF_MAX_CELL_WIDTH,
    parameter int MAX_CELL_HEIGHT = pgcb_pkg::DEF_MAX_CELL_HEIGHT
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [3:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output pgcb_pkg::pgcb_lim_t    lim
);
    import pgcb_pkg::*;

    logic [5:0] cell_width_reg;
    logic [5:0] cell_height_reg;
    logic [2:0] row_stride_reg;
    logic       wr_en;

    assign wr_en = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_width_reg  <= RESET_CELL_WIDTH;
            cell_height_reg <= RESET_CELL_HEIGHT;
            row_stride_reg  <= RESET_ROW_STRIDE;
        end
        else if (wr_en)
        begin
            case (paddr[3:2])
                REG_CELL_WIDTH:  cell_width_reg  <= pwdata[5:0];
                REG_CELL_HEIGHT: cell_height_reg <= pwdata[5:0];
                REG_ROW_STRIDE:  row_stride_reg  <= pwdata[2:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_CELL_WIDTH:  prdata = 32'(cell_width_reg);
            REG_CELL_HEIGHT: prdata = 32'(cell_height_reg);
            REG_ROW_STRIDE:  prdata = 32'(row_stride_reg);
            default:         prdata = 32'd0;
        endcase
    end

    always_comb
    begin
        lim.cw = (7'(cell_width_reg) > 7'(MAX_CELL_WIDTH)) ?
                 7'(MAX_CELL_WIDTH) : 7'(cell_width_reg);
        lim.ch = (7'(cell_height_reg) > 7'(MAX_CELL_HEIGHT)) ?
                 7'(MAX_CELL_HEIGHT) : 7'(cell_height_reg);
        lim.st = (row_stride_reg > MAX_STRIDE) ? MAX_STRIDE : row_stride_reg;
    end

endmodule

`default_nettype wire

// ===== rtl/pgcb_lane.sv =====
// ----------------------------------------------------------------------------
// pgcb_lane
// One pixel lane: places a glyph pixel in the cell, clips it and forms
// the store byte index and bit mask.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pgcb_lane #(
    parameter int COL_W = 6,
    parameter int ROW_W = 7
) (
    input  wire logic                 pixel_on,
    input  wire logic [COL_W-1:0]     col,
    input  wire logic [ROW_W-1:0]     row,
    input  wire logic signed [15:0]   x_offset,
    input  wire logic signed [15:0]   y_offset,
    input  wire pgcb_pkg::pgcb_lim_t  lim,
    output logic                      hit,
    output pgcb_pkg::pgcb_write_t     wr
);
    import pgcb_pkg::*;

    logic signed [16:0] x;
    logic signed [16:0] y;
    logic [9:0]         idx_wide;

    assign x = 17'(x_offset) + signed'(17'(col));
    assign y = 17'(y_offset) + signed'(17'(row));

    assign hit = pixel_on && !x[16] && !y[16] &&
                 (x[15:0] < 16'(lim.cw)) && (y[15:0] < 16'(lim.ch));

    // Inside the cell x and y are below 64, so six bits of each suffice.
    assign idx_wide = 10'(y[5:0]) * 10'(lim.st) + 10'(x[5:3]);

    assign wr.byte_index = idx_wide[6:0];
    assign wr.bit_mask   = LEFT_BIT >> x[2:0];

endmodule

`default_nettype wire

// ===== rtl/pgcb_drain.sv =====
// ----------------------------------------------------------------------------
// pgcb_drain
// Merge stage: holds the writes that the lanes found for one byte and sends
// them out in stream order, one beat per cycle while out_stall is low, through an output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pgcb_drain (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 load_valid,
    input  wire logic [pgcb_pkg::LANES-1:0]           load_hits,
    input  wire pgcb_pkg::pgcb_write_t [pgcb_pkg::LANES-1:0] load_writes,
    output logic                                      load_ready,
    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output logic [6:0]                                byte_index,
    output logic [7:0]                                bit_mask,
    output logic                                      last_of_run
);
    import pgcb_pkg::*;

    logic [LANES-1:0]  pend_reg;
    logic [LANES-1:0]  pend_next;
    pgcb_write_t [LANES-1:0] buf_reg;
    logic              o_valid_reg;
    pgcb_write_t       o_wr_reg;
    logic              o_last_reg;
    logic [SEL_W-1:0]  sel;
    logic [LANES-1:0]  sel_hot;
    logic [LANES-1:0]  pend_after;
    logic              out_free;
    logic              move;

    // Lane 0 carries the earliest pixel, so the lowest pending lane goes first.
    always_comb
    begin
        sel = '0;
        for (int k = LANES - 1; k >= 0; k--)
        begin
            if (pend_reg[k])
            begin
                sel = SEL_W'(k);
            end
        end
    end

    assign sel_hot    = LANES'(1) << sel;
    assign out_free   = !o_valid_reg || !out_stall;
    assign move       = (pend_reg != '0) && out_free;
    assign pend_after = move ? (pend_reg & ~sel_hot) : pend_reg;
    assign load_ready = (pend_after == '0);

    always_comb
    begin
        pend_next = pend_after;
        if (load_valid && load_ready)
        begin
            pend_next = load_hits;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg    <= '0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= pend_next;
            if (move)
            begin
                o_valid_reg <= 1'b1;
            end
            else if (out_free)
            begin
                o_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_valid && load_ready)
        begin
            buf_reg <= load_writes;
        end
        if (move)
        begin
            o_wr_reg   <= buf_reg[sel];
            o_last_reg <= ((pend_reg & ~sel_hot) == '0);
        end
    end

    assign out_valid   = o_valid_reg;
    assign byte_index  = o_wr_reg.byte_index;
    assign bit_mask    = o_wr_reg.bit_mask;
    assign last_of_run = o_last_reg;

endmodule

`default_nettype wire

// ===== rtl/pgcb_checker.sv =====
// ----------------------------------------------------------------------------
// pgcb_checker
// Port-level checks on the write channel of the packed glyph cell blit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "packed_glyph_cell_blit_macros.svh"

module pgcb_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire logic [6:0] byte_index,
    input wire logic [7:0] bit_mask,
    input wire logic       last_of_run
);

    // A stalled beat stays and holds its payload.
    `PGCB_ASSERT_NEXT(a_hold_valid, clk, rst_n, out_valid && out_stall, out_valid)
    `PGCB_ASSERT_NEXT(a_hold_data, clk, rst_n, out_valid && out_stall,
        $stable(byte_index) && $stable(bit_mask) && $stable(last_of_run))

    // Every write sets exactly one pixel.
    `PGCB_ASSERT_NOW(a_mask_onehot, clk, rst_n, out_valid, $onehot(bit_mask))

    // The rest of a byte's run is already buffered, so it follows at once.
    `PGCB_ASSERT_NEXT(a_run_continues, clk, rst_n,
        out_valid && !out_stall && !last_of_run, out_valid)

endmodule

bind packed_glyph_cell_blit pgcb_checker u_chk (.*);

`default_nettype wire

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for packed_glyph_cell_blit. Glyph bytes go in on a
// valid/stall channel and the expected OR-writes into the cell store are
// worked out beat by beat, then checked in order on the output channel.
// Cell geometry changes between phases over the APB-style register port.
// ----------------------------------------------------------------------------
module testbench;

    import pgcb_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_OFF_CYCLES = 400;

    typedef struct packed {
        logic [7:0]         src;
        logic               first;
        logic [6:0]         gw;
        logic [6:0]         gh;
        logic signed [15:0] dx;
        logic signed [15:0] dy;
    } glyph_beat_t;

    typedef struct packed {
        logic [6:0] byte_index;
        logic [7:0] bit_mask;
        logic       last_of_run;
    } cell_write_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [7:0]         src_byte;
    logic               first_byte;
    logic [6:0]         glyph_width;
    logic [6:0]         glyph_height;
    logic signed [15:0] x_offset;
    logic signed [15:0] y_offset;
    logic               out_valid;
    logic               out_stall;
    logic [6:0]         byte_index;
    logic [7:0]         bit_mask;
    logic               last_of_run;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [3:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    int unsigned cycle_count = 0;
    int          burst_left = 0;
    bit          hold_off_req = 1'b0;

    // Tracks the stream counters and cell geometry, and holds the writes
    // that the block still owes.
    class cell_write_board;
        logic [5:0]  cell_w;
        logic [5:0]  cell_h;
        logic [2:0]  stride;
        logic [5:0]  col;
        logic [6:0]  row;
        cell_write_t owed_writes[$];
        int          errors;

        function new();
            cell_w = RESET_CELL_WIDTH;
            cell_h = RESET_CELL_HEIGHT;
            stride = RESET_ROW_STRIDE;
            col = '0;
            row = '0;
            errors = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] value);
            case (idx)
                REG_CELL_WIDTH:  cell_w = value[5:0];
                REG_CELL_HEIGHT: cell_h = value[5:0];
                REG_ROW_STRIDE:  stride = value[2:0];
                default: ;
            endcase
        endfunction

        function void note_byte(glyph_beat_t bt);
            int cw, ch, st, x, y, dxi, dyi, b;
            cell_write_t w;
            cell_write_t run_writes[$];
            if (bt.first)
            begin
                col = '0;
                row = '0;
            end
            if (bt.gw == 0 || bt.gh == 0 || bt.gw > DEF_MAX_GLYPH_SIDE
                    || bt.gh > DEF_MAX_GLYPH_SIDE)
                return;
            cw = (cell_w > DEF_MAX_CELL_WIDTH) ? DEF_MAX_CELL_WIDTH : int'(cell_w);
            ch = (cell_h > DEF_MAX_CELL_HEIGHT) ? DEF_MAX_CELL_HEIGHT : int'(cell_h);
            st = (stride > MAX_STRIDE) ? int'(MAX_STRIDE) : int'(stride);
            dxi = bt.dx;
            dyi = bt.dy;
            for (b = 7; b >= 0; b--)
            begin
                // Once the glyph is complete the rest of the byte is padding.
                if (int'(row) >= int'(bt.gh))
                    break;
                if (bt.src[b])
                begin
                    x = dxi + int'(col);
                    y = dyi + int'(row);
                    if (x >= 0 && y >= 0 && x < cw && y < ch)
                    begin
                        w.byte_index = 7'(y * st + x / 8);
                        w.bit_mask = LEFT_BIT >> (x % 8);
                        w.last_of_run = 1'b0;
                        run_writes.push_back(w);
                    end
                end
                // A width that shrank mid-glyph ends the row after this bit.
                if (int'(col) + 1 >= int'(bt.gw))
                begin
                    col = '0;
                    row = row + 1'b1;
                end
                else
                begin
                    col = col + 1'b1;
                end
            end
            foreach (run_writes[i])
            begin
                w = run_writes[i];
                w.last_of_run = (i == run_writes.size() - 1);
                owed_writes.push_back(w);
            end
        endfunction

        function void check_write(logic [6:0] idx, logic [7:0] mask, logic last);
            cell_write_t w;
            if (owed_writes.size() == 0)
            begin
                $error("unexpected write: byte_index %0d bit_mask %02h", idx, mask);
                errors++;
                return;
            end
            w = owed_writes.pop_front();
            if (idx !== w.byte_index)
            begin
                $error("byte_index: expected %0d, actual %0d", w.byte_index, idx);
                errors++;
            end
            if (mask !== w.bit_mask)
            begin
                $error("bit_mask: expected %02h, actual %02h", w.bit_mask, mask);
                errors++;
            end
            if (last !== w.last_of_run)
            begin
                $error("last_of_run: expected %0d, actual %0d", w.last_of_run, last);
                errors++;
            end
        endfunction

        function int pending();
            return owed_writes.size();
        endfunction
    endclass

    cell_write_board board = new();

    packed_glyph_cell_blit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .src_byte     (src_byte),
        .first_byte   (first_byte),
        .glyph_width  (glyph_width),
        .glyph_height (glyph_height),
        .x_offset     (x_offset),
        .y_offset     (y_offset),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .byte_index   (byte_index),
        .bit_mask     (bit_mask),
        .last_of_run  (last_of_run),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            board.check_write(byte_index, bit_mask, last_of_run);
    end

    // Receiver: segments of stall patterns, plus one long hold-off on request.
    initial
    begin : receiver
        int seg, mode;
        out_stall = 1'b0;
        @(posedge clk);
        forever
        begin
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            mode = $urandom_range(0, 3);
            seg = $urandom_range(10, 80);
            while (seg > 0 && !hold_off_req)
            begin
                case (mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 2) == 0);
                    2: out_stall <= ~out_stall;
                    default: out_stall <= ($urandom_range(0, 3) != 0);
                endcase
                @(posedge clk);
                seg--;
            end
        end
    end

    function automatic glyph_beat_t beat(logic [7:0] src, logic first, logic [6:0] gw,
                                         logic [6:0] gh, logic [15:0] dx, logic [15:0] dy);
        glyph_beat_t bt;
        bt.src = src;
        bt.first = first;
        bt.gw = gw;
        bt.gh = gh;
        bt.dx = dx;
        bt.dy = dy;
        return bt;
    endfunction

    task automatic send_beat(input glyph_beat_t bt);
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 50)
                                                     : $urandom_range(1, 10);
        end
        in_valid <= 1'b1;
        src_byte <= bt.src;
        first_byte <= bt.first;
        glyph_width <= bt.gw;
        glyph_height <= bt.gh;
        x_offset <= bt.dx;
        y_offset <= bt.dy;
        do
            @(posedge clk);
        while (in_stall);
        board.note_byte(bt);
        burst_left--;
    endtask

    // Waits until every owed write has come out and the pipeline has emptied.
    task automatic drain();
        in_valid <= 1'b0;
        burst_left = 0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        board.set_reg(idx, value);
        @(posedge clk);
    endtask

    task automatic set_cell(input int cw, input int ch, input int st);
        write_reg(REG_CELL_WIDTH, cw);
        write_reg(REG_CELL_HEIGHT, ch);
        write_reg(REG_ROW_STRIDE, st);
    endtask

    // Mostly whole glyphs with random pixels, some late bytes and mid-glyph
    // width changes, and a share of fully random beats.
    task automatic run_glyphs(input int target);
        glyph_beat_t bt;
        int sent, nbytes, extra, k;
        sent = 0;
        while (sent < target)
        begin
            if ($urandom_range(0, 6) == 0)
            begin
                bt = beat(8'($urandom), 1'($urandom), 7'($urandom), 7'($urandom),
                          16'($urandom), 16'($urandom));
                send_beat(bt);
                sent++;
            end
            else
            begin
                if ($urandom_range(0, 15) == 0)
                begin
                    bt.gw = 7'($urandom_range(1, 64));
                    bt.gh = 7'($urandom_range(1, 64));
                end
                else
                begin
                    bt.gw = 7'($urandom_range(1, 12));
                    bt.gh = 7'($urandom_range(1, 12));
                end
                bt.dx = ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                                    : 16'(int'($urandom_range(0, 44)) - 12);
                bt.dy = ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                                    : 16'(int'($urandom_range(0, 44)) - 12);
                nbytes = (int'(bt.gw) * int'(bt.gh) + 7) / 8;
                if (nbytes > 24)
                    nbytes = 24;
                extra = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
                for (k = 0; k < nbytes + extra; k++)
                begin
                    case ($urandom_range(0, 5))
                        0: bt.src = 8'hFF;
                        1: bt.src = 8'h00;
                        default: bt.src = 8'($urandom);
                    endcase
                    bt.first = (k == 0);
                    if ($urandom_range(0, 19) == 0)
                        bt.gw = 7'($urandom_range(1, 64));
                    send_beat(bt);
                    sent++;
                end
            end
        end
    endtask

    initial
    begin
        int phase;
        rst_n = 1'b0;
        in_valid = 1'b0;
        src_byte = '0;
        first_byte = 1'b0;
        glyph_width = 7'd1;
        glyph_height = 7'd1;
        x_offset = '0;
        y_offset = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed beats at the reset geometry of 8 by 16, stride 1.
        send_beat(beat(8'hFF, 1'b1, 7'd8, 7'd2, 16'd0, 16'd0));
        send_beat(beat(8'hFF, 1'b0, 7'd8, 7'd2, 16'd0, 16'd0));
        send_beat(beat(8'hFF, 1'b0, 7'd8, 7'd2, 16'd0, 16'd0));   // glyph already complete
        send_beat(beat(8'hFF, 1'b1, 7'd3, 7'd3, 16'd0, 16'd0));
        send_beat(beat(8'hFF, 1'b0, 7'd3, 7'd3, 16'd0, 16'd0));   // one pixel, then padding
        send_beat(beat(8'hFF, 1'b1, 7'd0, 7'd3, 16'd0, 16'd0));
        send_beat(beat(8'hFF, 1'b0, 7'd65, 7'd3, 16'd0, 16'd0));
        send_beat(beat(8'hFF, 1'b0, 7'd3, 7'd0, 16'd0, 16'd0));
        send_beat(beat(8'hFF, 1'b0, 7'd3, 7'd127, 16'd0, 16'd0));
        send_beat(beat(8'hA5, 1'b0, 7'd64, 7'd64, 16'd0, 16'd0));
        send_beat(beat(8'hFF, 1'b1, 7'd8, 7'd4, -16'sd3, 16'd0));
        send_beat(beat(8'hFF, 1'b1, 7'd8, 7'd4, 16'd4, -16'sd1));
        send_beat(beat(8'hFF, 1'b1, 7'd8, 7'd2, 16'h7FFF, 16'd0));
        send_beat(beat(8'hFF, 1'b1, 7'd8, 7'd2, 16'h8000, 16'h8000));
        send_beat(beat(8'hFF, 1'b1, 7'd4, 7'd4, 16'd0, 16'h7FFF));
        send_beat(beat(8'hFF, 1'b1, 7'd8, 7'd8, 16'd0, 16'd15));
        send_beat(beat(8'h80, 1'b1, 7'd8, 7'd3, 16'd7, 16'd0));
        send_beat(beat(8'h01, 1'b0, 7'd8, 7'd3, 16'd7, 16'd0));
        send_beat(beat(8'hFF, 1'b1, 7'd16, 7'd4, 16'd0, 16'd0));
        send_beat(beat(8'hFF, 1'b0, 7'd3, 7'd4, 16'd0, 16'd0));    // width shrinks mid-row
        send_beat(beat(8'h00, 1'b1, 7'd8, 7'd8, 16'd0, 16'd0));
        send_beat(beat(8'hFF, 1'b1, 7'd1, 7'd64, 16'd0, 16'd0));
        drain();

        for (phase = 0; phase < 9; phase++)
        begin
            case (phase)
                0: set_cell(32, 32, 4);
                1: set_cell(1, 1, 1);
                2: set_cell(63, 63, 7);     // saturates to the largest cell
                3: set_cell(0, 8, 2);       // zero width clips everything
                4: set_cell(12, 0, 3);
                5: set_cell(20, 24, 0);     // every row lands on store row 0
                6: set_cell(17, 9, 5);
                7: set_cell($urandom_range(1, 32), $urandom_range(1, 32), $urandom_range(1, 4));
                default: set_cell(int'(RESET_CELL_WIDTH), int'(RESET_CELL_HEIGHT),
                                  int'(RESET_ROW_STRIDE));
            endcase
            if (phase == 0)
                hold_off_req = 1'b1;
            run_glyphs(36);
            drain();
        end

        if (board.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
